### src/mmcs_pkg.sv
// Types, constants and helpers shared by the memory-mapped CPU stepper.
package mmcs_pkg;

   localparam int DATA_DEPTH_DEF = 4096;
   localparam int PROG_DEPTH_DEF = 1024;

   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_LOAD  = 3'd2;
   localparam logic [2:0] CMD_STEP  = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   localparam logic [4:0] OP_HOLE   = 5'd0;
   localparam logic [4:0] OP_SET    = 5'd1;
   localparam logic [4:0] OP_CPY    = 5'd2;
   localparam logic [4:0] OP_CPYI   = 5'd3;
   localparam logic [4:0] OP_CPYI2  = 5'd4;
   localparam logic [4:0] OP_ADD    = 5'd5;
   localparam logic [4:0] OP_ADDI   = 5'd6;
   localparam logic [4:0] OP_SUBI   = 5'd7;
   localparam logic [4:0] OP_STOREI = 5'd8;
   localparam logic [4:0] OP_LOADI  = 5'd9;
   localparam logic [4:0] OP_JIF    = 5'd10;
   localparam logic [4:0] OP_PUSH   = 5'd11;
   localparam logic [4:0] OP_POP    = 5'd12;
   localparam logic [4:0] OP_CALL   = 5'd13;
   localparam logic [4:0] OP_RET    = 5'd14;
   localparam logic [4:0] OP_HLT    = 5'd15;
   localparam logic [4:0] OP_USER   = 5'd16;
   localparam logic [4:0] OP_PRN    = 5'd17;
   localparam logic [4:0] OP_HLTTH  = 5'd18;
   localparam logic [4:0] OP_YIELD  = 5'd19;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_UNKNOWN = 3'd4;
   localparam logic [2:0] EV_MEMORY  = 3'd5;
   localparam logic [2:0] EV_ARITH   = 3'd6;

   localparam logic [2:0] CSR_PROG_LEN   = 3'd0;
   localparam logic [2:0] CSR_USER_START = 3'd1;
   localparam logic [2:0] CSR_SPEC_BASE  = 3'd2;
   localparam logic [2:0] CSR_SYSCALL    = 3'd3;
   localparam logic [2:0] CSR_MEM_FAULT  = 3'd4;
   localparam logic [2:0] CSR_UNKNOWN    = 3'd5;
   localparam logic [2:0] CSR_ARITH      = 3'd6;

   typedef struct packed {
      logic [2:0]         command;
      logic [11:0]        data_address;
      logic signed [31:0] data_value;
      logic [9:0]         slot;
      logic [4:0]         opcode;
      logic signed [31:0] first_arg;
      logic signed [31:0] second_arg;
      logic [1:0]         operand_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               print_valid;
      logic signed [31:0] print_value;
      logic               halted;
      logic               user_mode;
      logic [2:0]         trap_event;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [31:0] first_arg;
      logic [31:0] second_arg;
      logic [1:0]  operand_count;
   } instr_type;

   typedef struct packed {
      logic [10:0] program_length;
      logic [12:0] user_memory_start;
      logic [11:0] special_base;
      logic [9:0]  syscall_entry;
      logic [9:0]  memory_fault_entry;
      logic [9:0]  unknown_instr_entry;
      logic [9:0]  arithmetic_fault_entry;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CMDRD, ST_PC, ST_BND, ST_FETCH, ST_EXEC, ST_RWAIT,
      ST_T4, ST_T3, ST_T5, ST_CNTR, ST_CNTW, ST_PCW, ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      ACT_END, ACT_RD, ACT_WR, ACT_RDS, ACT_WRS, ACT_FAULT
   } act_type;

   typedef enum logic [1:0] {
      FLT_GEN, FLT_MEM, FLT_STACK, FLT_BOUNDS
   } fault_type;

   typedef enum logic [1:0] {
      DST_X, DST_Y, DST_Z
   } dst_type;

   function automatic logic [1:0] need_args(input logic [4:0] op);
      logic [1:0] n;
      case (op)
         OP_SET, OP_CPY, OP_CPYI, OP_CPYI2, OP_ADD, OP_ADDI, OP_SUBI, OP_STOREI,
         OP_LOADI, OP_JIF: n = 2'd2;
         OP_PUSH, OP_POP, OP_CALL, OP_USER, OP_PRN: n = 2'd1;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

### src/mmcs_if.sv
// Request and response channel interfaces.
interface mmcs_req_if;
   import mmcs_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mmcs_rsp_if;
   import mmcs_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/mmcs_ram.sv
// Single-port synchronous RAM, one write and one registered read per cycle at one address.
module mmcs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### src/mmcs_seq.sv
// Command sequencer: decodes requests and steps instructions over the memories.
module mmcs_seq #(
   parameter int DATA_DEPTH = mmcs_pkg::DATA_DEPTH_DEF,
   parameter int PROG_DEPTH = mmcs_pkg::PROG_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mmcs_pkg::cfg_type             cfg,
   mmcs_req_if.sink                      req,
   mmcs_rsp_if.source                    rsp,
   output logic                          dm_we,
   output logic                          dm_re,
   output logic [$clog2(DATA_DEPTH)-1:0] dm_addr,
   output logic [31:0]                   dm_wdata,
   input  logic [31:0]                   dm_rdata,
   output logic                          pm_we,
   output logic                          pm_re,
   output logic [$clog2(PROG_DEPTH)-1:0] pm_addr,
   output mmcs_pkg::instr_type           pm_wdata,
   input  mmcs_pkg::instr_type           pm_rdata
);
   import mmcs_pkg::*;

   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int PAW = $clog2(PROG_DEPTH);
   localparam logic [31:0] DEPTH32 = 32'(DATA_DEPTH);
   localparam logic [31:0] PDEPTH32 = 32'(PROG_DEPTH);
   localparam logic [DAW:0] DEPTHX = (DAW+1)'(DATA_DEPTH);

   state_type  st_ff, st_in;
   logic [2:0] ph_ff, ph_in;
   logic [31:0] cur_ff, cur_in, nxt_ff, nxt_in;
   logic [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   instr_type  ins_ff, ins_in;
   dst_type    dst_ff, dst_in;
   logic       jmp_ff, jmp_in, pcw_ff, pcw_in;
   logic       halt_ff, halt_in, user_ff, user_in;
   logic       trap_ff, trap_in, targ_do_ff, targ_do_in;
   logic [31:0] tsave_ff, tsave_in, targ_ff, targ_in;
   logic [2:0] ev_ff, ev_in;
   logic       pv_ff, pv_in;
   logic [31:0] pval_ff, pval_in, rval_ff, rval_in;
   logic       rspv_ff, rspv_in;
   rsp_type    rsp_ff, rsp_in;

   logic [22:0]    bm_v;
   logic [DAW:0]   sx;
   logic [DAW-1:0] sa [6];

   act_type    act;
   logic [31:0] act_addr, act_data;
   dst_type    act_dst;
   fault_type  act_flt;

   logic [31:0] a1, a2, spsub, spadd;
   logic        cnt_ok, is_sys, ueff, memf, genf;
   logic        f_go, f_user;
   fault_type   f_kind;
   logic [31:0] f_addr;

   // special word addresses, base wrapped modulo the data depth
   always_comb begin
      bm_v = 23'(cfg.special_base);
      for (int i = 6; i >= 0; i--) begin
         if (bm_v >= 23'(DATA_DEPTH << i)) begin
            bm_v = bm_v - 23'(DATA_DEPTH << i);
         end
      end
      for (int k = 0; k < 6; k++) begin
         sx = (DAW+1)'(bm_v) + (DAW+1)'(k);
         if (sx >= DEPTHX) begin
            sx = sx - DEPTHX;
         end
         sa[k] = sx[DAW-1:0];
      end
   end

   assign a1     = ins_ff.first_arg;
   assign a2     = ins_ff.second_arg;
   assign spsub  = y_ff - 32'd1;
   assign spadd  = y_ff + 32'd1;
   assign cnt_ok = ins_ff.operand_count == need_args(ins_ff.opcode);
   assign is_sys = ins_ff.opcode >= OP_PRN && ins_ff.opcode <= OP_YIELD;
   assign ueff   = user_ff && !(is_sys && cnt_ok);
   assign memf   = ueff && !act_addr[31] && act_addr < 32'(cfg.user_memory_start);
   assign genf   = act_addr[31] || act_addr >= DEPTH32;

   // micro-op for the current phase of the instruction
   always_comb begin
      act      = ACT_END;
      act_addr = '0;
      act_data = '0;
      act_dst  = DST_X;
      act_flt  = FLT_GEN;
      if (ins_ff.opcode == OP_HOLE || ins_ff.opcode > OP_YIELD) begin
         act = ACT_END;
      end else if (!cnt_ok) begin
         act = ACT_FAULT;
      end else begin
         case (ins_ff.opcode)
            OP_SET: begin
               if (ph_ff == 3'd0) begin
                  act = ACT_WR; act_addr = a2; act_data = a1;
               end
            end
            OP_CPY: begin
               case (ph_ff)
                  3'd0: begin act = ACT_RD; act_addr = a1; end
                  3'd1: begin act = ACT_WR; act_addr = a2; act_data = x_ff; end
                  default: ;
               endcase
            end
            OP_CPYI, OP_LOADI: begin
               case (ph_ff)
                  3'd0: begin act = ACT_RD; act_addr = a1; end
                  3'd1: begin act = ACT_RD; act_addr = x_ff; act_dst = DST_Y; end
                  3'd2: begin act = ACT_WR; act_addr = a2; act_data = y_ff; end
                  default: ;
               endcase
            end
            OP_CPYI2: begin
               case (ph_ff)
                  3'd0: begin act = ACT_RD; act_addr = a1; end
                  3'd1: begin act = ACT_RD; act_addr = a2; act_dst = DST_Y; end
                  3'd2: begin act = ACT_RD; act_addr = x_ff; act_dst = DST_Z; end
                  3'd3: begin act = ACT_WR; act_addr = y_ff; act_data = z_ff; end
                  default: ;
               endcase
            end
            OP_ADD: begin
               case (ph_ff)
                  3'd0: begin act = ACT_RD; act_addr = a1; end
                  3'd1: begin act = ACT_WR; act_addr = a1; act_data = x_ff + a2; end
                  default: ;
               endcase
            end
            OP_ADDI, OP_SUBI, OP_STOREI: begin
               case (ph_ff)
                  3'd0: begin act = ACT_RD; act_addr = a1; end
                  3'd1: begin act = ACT_RD; act_addr = a2; act_dst = DST_Y; end
                  3'd2: begin
                     act = ACT_WR;
                     if (ins_ff.opcode == OP_ADDI) begin
                        act_addr = a1; act_data = x_ff + y_ff;
                     end else if (ins_ff.opcode == OP_SUBI) begin
                        act_addr = a2; act_data = x_ff - y_ff;
                     end else begin
                        act_addr = y_ff; act_data = x_ff;
                     end
                  end
                  default: ;
               endcase
            end
            OP_JIF, OP_USER, OP_PRN: begin
               if (ph_ff == 3'd0) begin
                  act = ACT_RD; act_addr = a1;
               end
            end
            OP_PUSH, OP_CALL: begin
               case (ph_ff)
                  3'd0: begin act = ACT_RDS; act_addr = 32'(sa[1]); act_dst = DST_Y; end
                  3'd1: begin
                     if (y_ff[31] || y_ff == 32'd0) begin
                        act = ACT_FAULT; act_flt = FLT_STACK;
                     end else begin
                        act = ACT_WRS; act_addr = 32'(sa[1]); act_data = spsub;
                     end
                  end
                  3'd2: begin
                     if (ins_ff.opcode == OP_CALL) begin
                        act = ACT_WR; act_addr = spsub; act_data = cur_ff + 32'd1;
                     end else begin
                        act = ACT_RD; act_addr = a1;
                     end
                  end
                  3'd3: begin
                     if (ins_ff.opcode == OP_PUSH) begin
                        act = ACT_WR; act_addr = spsub; act_data = x_ff;
                     end
                  end
                  default: ;
               endcase
            end
            OP_POP, OP_RET: begin
               case (ph_ff)
                  3'd0: begin act = ACT_RDS; act_addr = 32'(sa[1]); act_dst = DST_Y; end
                  3'd1: begin act = ACT_RD; act_addr = y_ff; end
                  3'd2: begin act = ACT_WRS; act_addr = 32'(sa[1]); act_data = spadd; end
                  3'd3: begin
                     if (ins_ff.opcode == OP_POP) begin
                        act = ACT_WR; act_addr = a1; act_data = x_ff;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         halt_ff <= 1'b0;
         user_ff <= 1'b0;
         rspv_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         halt_ff <= halt_in;
         user_ff <= user_in;
         rspv_ff <= rspv_in;
      end
      ph_ff      <= ph_in;
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      ins_ff     <= ins_in;
      dst_ff     <= dst_in;
      jmp_ff     <= jmp_in;
      pcw_ff     <= pcw_in;
      trap_ff    <= trap_in;
      targ_do_ff <= targ_do_in;
      tsave_ff   <= tsave_in;
      targ_ff    <= targ_in;
      ev_ff      <= ev_in;
      pv_ff      <= pv_in;
      pval_ff    <= pval_in;
      rval_ff    <= rval_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      st_in = st_ff;    ph_in = ph_ff;     cur_in = cur_ff;   nxt_in = nxt_ff;
      x_in = x_ff;      y_in = y_ff;       z_in = z_ff;       ins_in = ins_ff;
      dst_in = dst_ff;  jmp_in = jmp_ff;   pcw_in = pcw_ff;   halt_in = halt_ff;
      user_in = user_ff; trap_in = trap_ff; targ_do_in = targ_do_ff;
      tsave_in = tsave_ff; targ_in = targ_ff; ev_in = ev_ff; pv_in = pv_ff;
      pval_in = pval_ff; rval_in = rval_ff; rsp_in = rsp_ff;
      rspv_in = rspv_ff && !rsp.ready;
      req.ready = 1'b0;
      dm_we = 1'b0; dm_re = 1'b0; dm_addr = '0; dm_wdata = '0;
      pm_we = 1'b0; pm_re = 1'b0; pm_addr = '0; pm_wdata = '0;
      f_go = 1'b0; f_kind = FLT_GEN; f_addr = '0; f_user = user_ff;

      case (st_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               rval_in = '0; pv_in = 1'b0; pval_in = '0; ev_in = EV_NONE;
               st_in = ST_RESP;
               case (req.payload.command)
                  CMD_WRITE: begin
                     if (32'(req.payload.data_address) < DEPTH32) begin
                        dm_we    = 1'b1;
                        dm_addr  = DAW'(req.payload.data_address);
                        dm_wdata = req.payload.data_value;
                     end
                  end
                  CMD_READ: begin
                     if (32'(req.payload.data_address) < DEPTH32) begin
                        dm_re   = 1'b1;
                        dm_addr = DAW'(req.payload.data_address);
                        st_in   = ST_CMDRD;
                     end
                  end
                  CMD_LOAD: begin
                     if (32'(req.payload.slot) < PDEPTH32) begin
                        pm_we    = 1'b1;
                        pm_addr  = PAW'(req.payload.slot);
                        pm_wdata = {req.payload.opcode, req.payload.first_arg,
                                    req.payload.second_arg, req.payload.operand_count};
                     end
                  end
                  CMD_STEP: begin
                     if (!halt_ff) begin
                        dm_re   = 1'b1;
                        dm_addr = sa[0];
                        jmp_in = 1'b0; pcw_in = 1'b0; trap_in = 1'b0; targ_do_in = 1'b0;
                        st_in = ST_PC;
                     end
                  end
                  CMD_CLEAR: begin
                     halt_in = 1'b0;
                     user_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_CMDRD: begin
            rval_in = dm_rdata;
            st_in   = ST_RESP;
         end
         ST_PC: begin
            cur_in = dm_rdata;
            nxt_in = dm_rdata + 32'd1;
            st_in  = ST_BND;
         end
         ST_BND: begin
            if (!cur_ff[31] && cur_ff < 32'(cfg.program_length) && cur_ff < PDEPTH32) begin
               pm_re   = 1'b1;
               pm_addr = cur_ff[PAW-1:0];
               st_in   = ST_FETCH;
            end else begin
               f_go = 1'b1; f_kind = FLT_BOUNDS;
            end
         end
         ST_FETCH: begin
            ins_in = pm_rdata;
            ph_in  = 3'd0;
            st_in  = ST_EXEC;
         end
         ST_EXEC: begin
            case (act)
               ACT_RD, ACT_WR: begin
                  f_user = ueff;
                  if (memf) begin
                     f_go = 1'b1; f_kind = FLT_MEM; f_addr = act_addr;
                  end else if (genf) begin
                     f_go = 1'b1; f_kind = FLT_GEN;
                  end else if (act == ACT_RD) begin
                     dm_re = 1'b1; dm_addr = act_addr[DAW-1:0];
                     dst_in = act_dst; st_in = ST_RWAIT;
                  end else begin
                     dm_we = 1'b1; dm_addr = act_addr[DAW-1:0]; dm_wdata = act_data;
                     if (act_addr[DAW-1:0] == sa[0]) begin
                        pcw_in = 1'b1;
                     end
                     ph_in = ph_ff + 3'd1;
                  end
               end
               ACT_RDS: begin
                  dm_re = 1'b1; dm_addr = act_addr[DAW-1:0];
                  dst_in = act_dst; st_in = ST_RWAIT;
               end
               ACT_WRS: begin
                  dm_we = 1'b1; dm_addr = act_addr[DAW-1:0]; dm_wdata = act_data;
                  ph_in = ph_ff + 3'd1;
               end
               ACT_FAULT: begin
                  f_go = 1'b1; f_kind = act_flt; f_user = ueff;
               end
               default: begin
                  st_in = ST_CNTR;
                  case (ins_ff.opcode)
                     OP_HOLE, OP_HLT: begin
                        halt_in = 1'b1; nxt_in = cur_ff; jmp_in = 1'b1;
                     end
                     OP_JIF: begin
                        if (x_ff[31] || x_ff == 32'd0) begin
                           nxt_in = a2; jmp_in = 1'b1;
                        end
                     end
                     OP_CALL: begin
                        nxt_in = a1; jmp_in = 1'b1;
                     end
                     OP_RET: begin
                        nxt_in = x_ff; jmp_in = 1'b1;
                     end
                     OP_USER: begin
                        nxt_in = x_ff; user_in = 1'b1; jmp_in = 1'b1;
                     end
                     OP_PRN, OP_HLTTH, OP_YIELD: begin
                        user_in = 1'b0; jmp_in = 1'b1; trap_in = 1'b1;
                        tsave_in = cur_ff + 32'd1;
                        ev_in = 3'(ins_ff.opcode - OP_USER);
                        nxt_in = 32'(cfg.syscall_entry);
                        st_in = ST_T4;
                        if (ins_ff.opcode == OP_PRN) begin
                           pv_in = 1'b1; pval_in = x_ff;
                           targ_do_in = 1'b1; targ_in = a1;
                        end
                     end
                     default: begin
                        if (ins_ff.opcode > OP_YIELD) begin
                           jmp_in = 1'b1;
                           if (user_ff) begin
                              user_in = 1'b0; trap_in = 1'b1; tsave_in = cur_ff;
                              ev_in = EV_UNKNOWN;
                              nxt_in = 32'(cfg.unknown_instr_entry);
                              st_in = ST_T4;
                           end else begin
                              halt_in = 1'b1; nxt_in = cur_ff;
                           end
                        end
                     end
                  endcase
               end
            endcase
         end
         ST_RWAIT: begin
            case (dst_ff)
               DST_Y:   y_in = dm_rdata;
               DST_Z:   z_in = dm_rdata;
               default: x_in = dm_rdata;
            endcase
            ph_in = ph_ff + 3'd1;
            st_in = ST_EXEC;
         end
         ST_T4: begin
            dm_we = 1'b1; dm_addr = sa[4]; dm_wdata = tsave_ff;
            st_in = ST_T3;
         end
         ST_T3: begin
            dm_we = 1'b1; dm_addr = sa[3]; dm_wdata = 32'(ev_ff);
            st_in = targ_do_ff ? ST_T5 : ST_CNTR;
         end
         ST_T5: begin
            dm_we = 1'b1; dm_addr = sa[5]; dm_wdata = targ_ff;
            st_in = ST_CNTR;
         end
         ST_CNTR: begin
            dm_re = 1'b1; dm_addr = sa[2];
            st_in = ST_CNTW;
         end
         ST_CNTW: begin
            dm_we = 1'b1; dm_addr = sa[2]; dm_wdata = dm_rdata + 32'd1;
            st_in = (!halt_ff && (jmp_ff || !pcw_ff)) ? ST_PCW : ST_RESP;
         end
         ST_PCW: begin
            dm_we = 1'b1; dm_addr = sa[0]; dm_wdata = nxt_ff;
            st_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rspv_ff || rsp.ready) begin
               rspv_in = 1'b1;
               rsp_in.read_value  = rval_ff;
               rsp_in.print_valid = pv_ff;
               rsp_in.print_value = pval_ff;
               rsp_in.halted      = halt_ff;
               rsp_in.user_mode   = user_ff;
               rsp_in.trap_event  = ev_ff;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (f_go) begin
         jmp_in  = 1'b1;
         user_in = 1'b0;
         st_in   = ST_T4;
         trap_in = 1'b1;
         tsave_in = cur_ff;
         if (f_kind == FLT_MEM) begin
            ev_in = EV_MEMORY; nxt_in = 32'(cfg.memory_fault_entry);
            targ_do_in = 1'b1; targ_in = f_addr;
         end else if (f_user && f_kind == FLT_STACK) begin
            ev_in = EV_MEMORY; nxt_in = 32'(cfg.memory_fault_entry);
         end else if (f_user && f_kind == FLT_BOUNDS) begin
            ev_in = EV_UNKNOWN; nxt_in = 32'(cfg.unknown_instr_entry);
         end else if (f_user) begin
            ev_in = EV_ARITH; nxt_in = 32'(cfg.arithmetic_fault_entry);
         end else begin
            trap_in = 1'b0; halt_in = 1'b1; nxt_in = cur_ff; st_in = ST_CNTR;
         end
      end
   end

   assign rsp.valid   = rspv_ff;
   assign rsp.payload = rsp_ff;

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(dm_we && dm_re))
      else $error("data memory read and write in one cycle");
   a_halted_step: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE && req.valid && req.payload.command == CMD_STEP && halt_ff)
      |=> (st_ff == ST_RESP && halt_ff))
      else $error("step while halted did work");
   a_trap_seq: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_T4) |=> (st_ff == ST_T3 && !user_ff))
      else $error("trap write sequence broken");
   a_cnt_seq: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CNTR) |=> (st_ff == ST_CNTW))
      else $error("count update split");
endmodule

### src/memory_mapped_cpu_step_with_traps.sv
// Top level of the memory-mapped CPU stepper: control registers, memories, sequencer.
//
// Each request is one command: write or read a data word, load a program slot, step
// one instruction, or clear the halted and user flags. Only one request is in flight;
// the result is held in an output register so the next request can be taken while it
// waits. A step reads the PC and fetches the slot, then makes each data read and write
// on the single data memory port, runs a closing state, writes any trap words, updates
// the count, writes the PC back when needed and sends the response; a step when already
// halted goes straight to the response. The memories have no reset and no clearing pass.
module memory_mapped_cpu_step_with_traps #(
   parameter int DATA_DEPTH = mmcs_pkg::DATA_DEPTH_DEF,
   parameter int PROG_DEPTH = mmcs_pkg::PROG_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mmcs_req_if.sink    req_port,
   mmcs_rsp_if.source  rsp_port,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data
);
   import mmcs_pkg::*;

   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int PAW = $clog2(PROG_DEPTH);

   cfg_type cfg_ff, cfg_in;

   logic           dm_we, dm_re;
   logic [DAW-1:0] dm_addr;
   logic [31:0]    dm_wdata, dm_rdata;
   logic           pm_we, pm_re;
   logic [PAW-1:0] pm_addr;
   instr_type      pm_wdata, pm_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PROG_LEN:   cfg_in.program_length         = csr_data[10:0];
            CSR_USER_START: cfg_in.user_memory_start      = csr_data;
            CSR_SPEC_BASE:  cfg_in.special_base           = csr_data[11:0];
            CSR_SYSCALL:    cfg_in.syscall_entry          = csr_data[9:0];
            CSR_MEM_FAULT:  cfg_in.memory_fault_entry     = csr_data[9:0];
            CSR_UNKNOWN:    cfg_in.unknown_instr_entry    = csr_data[9:0];
            CSR_ARITH:      cfg_in.arithmetic_fault_entry = csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmcs_ram #(.DEPTH(DATA_DEPTH), .WIDTH(32)) u_dmem (
      .clock (clock),
      .we    (dm_we),
      .re    (dm_re),
      .addr  (dm_addr),
      .wdata (dm_wdata),
      .rdata (dm_rdata)
   );

   mmcs_ram #(.DEPTH(PROG_DEPTH), .WIDTH($bits(instr_type))) u_pmem (
      .clock (clock),
      .we    (pm_we),
      .re    (pm_re),
      .addr  (pm_addr),
      .wdata (pm_wdata),
      .rdata (pm_rdata)
   );

   mmcs_seq #(.DATA_DEPTH(DATA_DEPTH), .PROG_DEPTH(PROG_DEPTH)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req_port),
      .rsp      (rsp_port),
      .dm_we    (dm_we),
      .dm_re    (dm_re),
      .dm_addr  (dm_addr),
      .dm_wdata (dm_wdata),
      .dm_rdata (dm_rdata),
      .pm_we    (pm_we),
      .pm_re    (pm_re),
      .pm_addr  (pm_addr),
      .pm_wdata (pm_wdata),
      .pm_rdata (pm_rdata)
   );
endmodule
